>>> rtl/u2u_pkg.sv
// Shared types, constants and lead-byte helpers for the UTF-8 to UTF-16LE transcoder.
// No dependencies; every other file in rtl/ uses this package by scoped name.
package u2u_pkg;

  localparam int unsigned CpW    = 21;   // widest decoded code point (4-byte lead)
  localparam int unsigned UnitW  = 16;
  localparam int unsigned MaxUnits = 3;

  localparam logic [CpW-1:0]   PlaneBase = 21'h10000;
  localparam logic [UnitW-1:0] HighSurr  = 16'hD800;
  localparam logic [UnitW-1:0] LowSurr   = 16'hDC00;
  localparam logic [9:0]       HalfMask  = 10'h3FF;
  localparam logic [7:0]       ContMask  = 8'h3F;

  // One queue entry: the complete set of code units caused by one input byte.
  typedef struct packed {
    logic [1:0]                      num;   // 1 to 3 units
    logic [MaxUnits-1:0][UnitW-1:0]  code;  // code[0] goes out first
    logic                            last;  // final unit carries the end flag
  } job_t;

  // Sequence length from a lead byte; bad leads count as length 1.
  function automatic logic [2:0] lead_len(input logic [7:0] lead);
    logic [2:0] len;
    if (lead < 8'h80)                len = 3'd1;
    else if ((lead & 8'hE0) == 8'hC0) len = 3'd2;
    else if ((lead & 8'hF0) == 8'hE0) len = 3'd3;
    else if ((lead & 8'hF8) == 8'hF0) len = 3'd4;
    else                              len = 3'd1;
    return len;
  endfunction

  // Payload bits of a multi-byte lead.
  function automatic logic [4:0] lead_payload(input logic [7:0] lead);
    logic [4:0] pay;
    if ((lead & 8'hE0) == 8'hC0)      pay = lead[4:0];
    else if ((lead & 8'hF0) == 8'hE0) pay = {1'b0, lead[3:0]};
    else                              pay = {2'b00, lead[2:0]};
    return pay;
  endfunction

endpackage

>>> rtl/u2u_front.sv
// Front end: accepts bytes, tracks the open sequence and builds one job per result set.
// Depends on u2u_pkg; feeds u2u_queue.
module u2u_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     in_byte_i,
  input  logic           last_byte_i,
  input  logic           q_full_i,
  output logic           push_o,
  output u2u_pkg::job_t  job_o
);

  logic [1:0]       pcnt_q, pcnt_d;
  logic [2:0]       need_q, need_d;
  logic [2:0][7:0]  pb_q;
  logic             accept;
  logic             store;
  logic             complete;
  logic [4:0]       pay;
  logic [u2u_pkg::CpW-1:0] cp, adj;
  u2u_pkg::job_t    cp_job;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Code point of the sequence closed by the current byte.
  assign pay = u2u_pkg::lead_payload(pb_q[0]);
  always_comb begin
    unique case (pcnt_q)
      2'd2:    cp = {5'b0, pay[3:0], pb_q[1][5:0], in_byte_i[5:0]};
      2'd3:    cp = {pay[2:0], pb_q[1][5:0], pb_q[2][5:0], in_byte_i[5:0]};
      default: cp = {10'b0, pay, in_byte_i[5:0]};
    endcase
  end

  assign adj = cp - u2u_pkg::PlaneBase;
  assign complete = (({1'b0, pcnt_q} + 3'd1) >= need_q);

  always_comb begin
    cp_job = '0;
    cp_job.last = last_byte_i;
    if (cp >= u2u_pkg::PlaneBase) begin
      cp_job.num     = 2'd2;
      cp_job.code[0] = u2u_pkg::HighSurr + {5'b0, adj[20:10]};
      cp_job.code[1] = u2u_pkg::LowSurr + {6'b0, adj[9:0] & u2u_pkg::HalfMask};
    end else begin
      cp_job.num     = 2'd1;
      cp_job.code[0] = cp[15:0];
    end
  end

  always_comb begin
    push_o = 1'b0;
    job_o  = '0;
    job_o.last = last_byte_i;
    store  = 1'b0;
    pcnt_d = pcnt_q;
    need_d = need_q;
    if (accept) begin
      if (pcnt_q == 2'd0) begin
        if (last_byte_i || u2u_pkg::lead_len(in_byte_i) == 3'd1) begin
          push_o        = 1'b1;
          job_o.num     = 2'd1;
          job_o.code[0] = {8'h00, in_byte_i};
        end else begin
          store  = 1'b1;
          pcnt_d = 2'd1;
          need_d = u2u_pkg::lead_len(in_byte_i);
        end
      end else if (complete) begin
        push_o = 1'b1;
        job_o  = cp_job;
        pcnt_d = 2'd0;
        need_d = 3'd0;
      end else if (!last_byte_i) begin
        store  = 1'b1;
        pcnt_d = pcnt_q + 2'd1;
      end else begin
        // Flush of a short sequence: lead alone, then the rest decoded afresh.
        push_o        = 1'b1;
        job_o.code[0] = {8'h00, pb_q[0]};
        pcnt_d        = 2'd0;
        need_d        = 3'd0;
        if (pcnt_q == 2'd1) begin
          job_o.num     = 2'd2;
          job_o.code[1] = {8'h00, in_byte_i};
        end else if ((pb_q[1] & 8'hE0) == 8'hC0) begin
          job_o.num     = 2'd2;
          job_o.code[1] = {5'b0, pb_q[1][4:0], in_byte_i[5:0] & u2u_pkg::ContMask[5:0]};
        end else begin
          job_o.num     = 2'd3;
          job_o.code[1] = {8'h00, pb_q[1]};
          job_o.code[2] = {8'h00, in_byte_i};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q <= 2'd0;
      need_q <= 3'd0;
    end else begin
      pcnt_q <= pcnt_d;
      need_q <= need_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      pb_q[pcnt_q] <= in_byte_i;
    end
  end

endmodule

>>> rtl/u2u_queue.sv
// Small job queue between the front and back ends, register based.
// Depends on u2u_pkg for the entry type.
module u2u_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  u2u_pkg::job_t  push_data_i,
  output logic           full_o,
  output logic           valid_o,
  output u2u_pkg::job_t  head_o,
  input  logic           pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  u2u_pkg::job_t        mem_q [Depth];
  logic [PtrW-1:0]      wr_q, rd_q;
  logic [CntW-1:0]      cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wrap_inc(wr_q);
      if (do_pop)  rd_q <= wrap_inc(rd_q);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/u2u_back.sv
// Back end: one head-job unit per cycle to the output register, unless stalled.
// Depends on u2u_pkg; reads u2u_queue.
module u2u_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  u2u_pkg::job_t  head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [15:0]    code_unit_o,
  output logic           last_unit_o
);

  logic        out_valid_q;
  logic [15:0] code_q;
  logic        last_q;
  logic [1:0]  idx_q;
  logic        load;
  logic        final_unit;

  assign load       = !out_valid_q || !out_stall_i;
  assign final_unit = (idx_q == head_i.num - 2'd1);
  assign pop_o      = load && q_valid_i && final_unit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else if (load) begin
      out_valid_q <= q_valid_i;
      if (q_valid_i) begin
        idx_q <= final_unit ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && q_valid_i) begin
      code_q <= head_i.code[idx_q];
      last_q <= head_i.last && final_unit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign code_unit_o = code_q;
  assign last_unit_o = last_q;

endmodule

>>> rtl/utf8_to_utf16le_transcoder_unit.sv
// UTF-8 to UTF-16LE transcoder, top level.
// Depends on u2u_pkg, u2u_front, u2u_queue and u2u_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one UTF-8 byte per
//   transaction plus last_byte_i, set on the final byte of a string. Output
//   channel (out_valid_o / out_stall_i) carries one UTF-16 code unit per
//   transaction plus last_unit_o, set on the final unit of the string.
//   A transaction completes on a rising edge with valid high and stall low.
// Throughput: one byte in and one code unit out per cycle, unless stalled.
//   A byte that closes a supplementary code point gives two units and a
//   final byte inside an unfinished sequence gives up to three; these drain
//   at the output rate of one unit per cycle, and the job queue (Depth
//   entries) absorbs the difference while the front keeps taking bytes.
// Path: the job is written into the queue at the edge that accepts the byte,
//   and its first unit is then loaded into the output register once the
//   queue holds nothing older and the output register is free.
// Reset: asynchronous, active low. Clears the open-sequence state, empties
//   the queue and drops out_valid_o.
// Receiver stall: the output register holds its unit; the queue fills, and
//   in_stall_o rises once it is full.
module utf8_to_utf16le_transcoder_unit #(
  parameter int unsigned Depth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] code_unit_o,
  output logic        last_unit_o
);

  logic           q_full;
  logic           q_valid;
  logic           push;
  logic           pop;
  u2u_pkg::job_t  push_job;
  u2u_pkg::job_t  head_job;

  // Classifies bytes, keeps the pending sequence and builds result jobs.
  u2u_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  // Decouples the byte rate from the unit rate.
  u2u_queue #(
    .Depth (Depth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (head_job),
    .pop_i       (pop)
  );

  // Serializes each job into code units behind the output register.
  u2u_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .head_i      (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .code_unit_o (code_unit_o),
    .last_unit_o (last_unit_o)
  );

  // The front never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_full)
    else $error("job pushed into full queue");

  // Every job carries at least one and at most three units.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> push_job.num != 2'd0)
    else $error("empty job pushed");

  // The back end only retires a job that is present.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> q_valid)
    else $error("pop from empty queue");

  // Popping a job that carries the end flag puts its final unit, flagged last, out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && head_job.last) |=> (out_valid_o && last_unit_o))
    else $error("end flag lost on final unit");

endmodule
